/* hdl/rac_pkg.sv */
// Shared types, constants and helpers for the rational add/sub/compare core.
package rac_pkg;

    // Operand width of every input numerator and denominator
    localparam int OPERAND_WIDTH = 16;
    // Internal magnitude width: holds any product or sum of two operands
    localparam int MAG_WIDTH     = 2 * OPERAND_WIDTH;
    localparam int NUM_OUT_WIDTH = 33;
    localparam int DEN_OUT_WIDTH = 32;

    typedef enum logic [1:0] {
        OP_NORM = 2'd0,
        OP_ADD  = 2'd1,
        OP_SUB  = 2'd2,
        OP_EQ   = 2'd3
    } t_op;

    typedef struct packed {
        t_op                             operation;
        logic signed [OPERAND_WIDTH-1:0] a_num;
        logic signed [OPERAND_WIDTH-1:0] a_den;
        logic signed [OPERAND_WIDTH-1:0] b_num;
        logic signed [OPERAND_WIDTH-1:0] b_den;
    } t_req;

    typedef struct packed {
        logic signed [NUM_OUT_WIDTH-1:0] result_num;
        logic [DEN_OUT_WIDTH-1:0]        result_den;
        logic                            equal;
        logic                            error;
    } t_rsp;

    // Divider operand selection
    typedef enum logic [1:0] {
        DS_GCD = 2'd0,   // x mod y
        DS_MAG = 2'd1,   // magnitude / gcd
        DS_DEN = 2'd2    // denominator / gcd
    } t_div_src;

    // Multiplier operand selection
    typedef enum logic [1:0] {
        MS_T1  = 2'd0,   // a.mag * b.den
        MS_T2  = 2'd1,   // b.mag * a.den
        MS_DEN = 2'd2    // a.den * b.den
    } t_mul_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GCD_TEST,
        ST_GCD_WAIT,
        ST_DIVM_WAIT,
        ST_DIVD_WAIT,
        ST_REDUCED,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_COMBINE,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_R
    } t_phase;

    // Controller to datapath commands
    typedef struct packed {
        logic     capture;
        logic     set_err;
        logic     load_a;
        logic     load_b;
        logic     save_a;
        logic     save_b;
        logic     div_start;
        t_div_src div_src;
        logic     gcd_update;
        logic     wr_mag;
        logic     wr_den;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     combine;
        logic     out_load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_op  op;
        logic err_zero;
        logic y_zero;
        logic div_done;
        logic out_valid;
    } t_dp_stat;

    // Magnitude of a two's complement operand; the most negative value maps exactly
    function automatic logic [OPERAND_WIDTH-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] raw);
        return raw[OPERAND_WIDTH-1] ? (~raw + OPERAND_WIDTH'(1)) : raw;
    endfunction

endpackage

/* hdl/rational_add_sub_compare_core.sv */
// Top level of the rational add/subtract/compare core.
//
//  Channel   Handshake                      Payload
//  request   i_req_valid / o_req_ready      i_req (t_req)
//  response  o_rsp_valid / i_rsp_ready      o_rsp (t_rsp)
//
// One request at a time. Each reduction runs Euclid on a shared 32-bit
// restoring divider and then divides both parts by the gcd. Normalize
// reduces once, equality twice, add/subtract three times, with the
// multiply and combine states before the third. A zero denominator skips
// the reduction and answers directly. Reset is synchronous, active low.
// A stalled response holds in its register; the next request is accepted
// meanwhile and waits in the last state until the register frees.
module rational_add_sub_compare_core import rac_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rac_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_req_ready (o_req_ready)
    );

    rac_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_rsp_ready (i_rsp_ready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_rsp       (o_rsp),
        .o_rsp_valid (o_rsp_valid)
    );

endmodule

/* hdl/rac_div.sv */
// Restoring shift-subtract divider, one quotient bit per cycle.
module rac_div import rac_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [MAG_WIDTH-1:0] i_dividend,
    input  logic [MAG_WIDTH-1:0] i_divisor,
    output logic [MAG_WIDTH-1:0] o_quot,
    output logic [MAG_WIDTH-1:0] o_rem,
    output logic                 o_done
);

    localparam int CNT_W = $clog2(MAG_WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [MAG_WIDTH-1:0] r_rem;
    logic [MAG_WIDTH-1:0] r_quo;
    logic [MAG_WIDTH-1:0] r_dvs;

    logic [MAG_WIDTH:0] w_shift;
    logic [MAG_WIDTH:0] w_diff;
    logic               w_ge;

    // Partial remainder step
    assign w_shift = {r_rem, r_quo[MAG_WIDTH-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = w_shift >= {1'b0, r_dvs};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MAG_WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[MAG_WIDTH-1:0] : w_shift[MAG_WIDTH-1:0];
            r_quo <= {r_quo[MAG_WIDTH-2:0], w_ge};
        end
    end

    assign o_quot = r_quo;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

/* hdl/rac_datapath.sv */
// Datapath: operand registers, Euclid registers, divider, multiplier, result register.
module rac_datapath import rac_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_req     i_req,
    input  logic     i_rsp_ready,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output t_rsp     o_rsp,
    output logic     o_rsp_valid
);

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = MAG_WIDTH;
    localparam int NX = (MW + 1 > NUM_OUT_WIDTH) ? MW + 1 : NUM_OUT_WIDTH;

    t_req          r_in;
    logic          r_err;
    logic          r_a_neg, r_b_neg, r_w_neg;
    logic [MW-1:0] r_a_mag, r_a_den, r_b_mag, r_b_den, r_w_mag, r_w_den;
    logic [MW-1:0] r_x, r_y;
    logic [MW-1:0] r_t1, r_t2;
    t_rsp          r_out;
    logic          r_out_valid;

    logic [MW-1:0] w_div_dvd, w_div_dvs, w_quot, w_rem;
    logic          w_div_done;
    logic [W-1:0]  w_mul_a, w_mul_b;
    logic [MW-1:0] w_prod;
    logic          w_bneg;
    logic [MW-1:0] w_comb_mag;
    logic          w_comb_neg;
    logic          w_src_neg;
    logic [MW-1:0] w_src_mag, w_src_den;
    logic signed [NX-1:0] w_num_ext;
    logic          w_eq;

    // Operand sign and magnitude of the captured request
    logic          w_an_neg, w_bn_neg;
    logic [MW-1:0] w_an_mag, w_ad_mag, w_bn_mag, w_bd_mag;

    assign w_an_neg = r_in.a_num[W-1] ^ r_in.a_den[W-1];
    assign w_bn_neg = r_in.b_num[W-1] ^ r_in.b_den[W-1];
    assign w_an_mag = MW'(mag_of(r_in.a_num));
    assign w_ad_mag = MW'(mag_of(r_in.a_den));
    assign w_bn_mag = MW'(mag_of(r_in.b_num));
    assign w_bd_mag = MW'(mag_of(r_in.b_den));

    // Divider operand select
    always_comb begin
        case (i_cmd.div_src)
            DS_GCD: begin
                w_div_dvd = r_x;
                w_div_dvs = r_y;
            end
            DS_MAG: begin
                w_div_dvd = r_w_mag;
                w_div_dvs = r_x;
            end
            DS_DEN: begin
                w_div_dvd = r_w_den;
                w_div_dvs = r_x;
            end
            default: begin
                w_div_dvd = r_x;
                w_div_dvs = r_y;
            end
        endcase
    end

    rac_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_quot     (w_quot),
        .o_rem      (w_rem),
        .o_done     (w_div_done)
    );

    // Shared multiplier; reduced magnitudes never exceed the operand range
    always_comb begin
        case (i_cmd.mul_sel)
            MS_T1: begin
                w_mul_a = r_a_mag[W-1:0];
                w_mul_b = r_b_den[W-1:0];
            end
            MS_T2: begin
                w_mul_a = r_b_mag[W-1:0];
                w_mul_b = r_a_den[W-1:0];
            end
            MS_DEN: begin
                w_mul_a = r_a_den[W-1:0];
                w_mul_b = r_b_den[W-1:0];
            end
            default: begin
                w_mul_a = r_a_mag[W-1:0];
                w_mul_b = r_b_den[W-1:0];
            end
        endcase
    end
    assign w_prod = MW'(w_mul_a) * MW'(w_mul_b);

    // Signed combine of the cross products
    assign w_bneg = (r_in.operation == OP_SUB) ? !r_b_neg : r_b_neg;
    always_comb begin
        if (r_a_neg == w_bneg) begin
            w_comb_mag = r_t1 + r_t2;
            w_comb_neg = r_a_neg;
        end else if (r_t1 >= r_t2) begin
            w_comb_mag = r_t1 - r_t2;
            w_comb_neg = r_a_neg;
        end else begin
            w_comb_mag = r_t2 - r_t1;
            w_comb_neg = w_bneg;
        end
    end

    // Result source: reduced a for equality, working fraction otherwise
    assign w_src_neg = (r_in.operation == OP_EQ) ? r_a_neg : r_w_neg;
    assign w_src_mag = (r_in.operation == OP_EQ) ? r_a_mag : r_w_mag;
    assign w_src_den = (r_in.operation == OP_EQ) ? r_a_den : r_w_den;
    assign w_num_ext = w_src_neg ? -$signed(NX'(w_src_mag)) : $signed(NX'(w_src_mag));
    assign w_eq      = (r_in.operation == OP_EQ) && (r_a_neg == r_w_neg)
                       && (r_a_mag == r_w_mag) && (r_a_den == r_w_den);

    // Request capture and error flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else if (i_cmd.capture) begin
            r_err <= 1'b0;
        end else if (i_cmd.set_err) begin
            r_err <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_req;
        end
    end

    // Working fraction and Euclid registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a) begin
            r_w_neg <= w_an_neg;
            r_w_mag <= w_an_mag;
            r_w_den <= w_ad_mag;
            r_x     <= w_an_mag;
            r_y     <= w_ad_mag;
        end else if (i_cmd.load_b) begin
            r_w_neg <= w_bn_neg;
            r_w_mag <= w_bn_mag;
            r_w_den <= w_bd_mag;
            r_x     <= w_bn_mag;
            r_y     <= w_bd_mag;
        end else if (i_cmd.combine) begin
            r_w_neg <= w_comb_neg;
            r_w_mag <= w_comb_mag;
            r_x     <= w_comb_mag;
            r_y     <= r_w_den;
        end else if (i_cmd.gcd_update) begin
            r_x <= r_y;
            r_y <= w_rem;
        end else if (i_cmd.wr_mag) begin
            r_w_mag <= w_quot;
        end else if (i_cmd.wr_den) begin
            // A zero numerator reduces to a positive 0/1
            if (r_w_mag == '0) begin
                r_w_neg <= 1'b0;
                r_w_den <= MW'(1);
            end else begin
                r_w_den <= w_quot;
            end
        end else if (i_cmd.mul_en && (i_cmd.mul_sel == MS_DEN)) begin
            r_w_den <= w_prod;
        end
    end

    // Saved reduced operands and cross products
    always_ff @(posedge i_clk) begin
        if (i_cmd.save_a) begin
            r_a_neg <= r_w_neg;
            r_a_mag <= r_w_mag;
            r_a_den <= r_w_den;
        end
        if (i_cmd.save_b) begin
            r_b_neg <= r_w_neg;
            r_b_mag <= r_w_mag;
            r_b_den <= r_w_den;
        end
        if (i_cmd.mul_en && (i_cmd.mul_sel == MS_T1)) begin
            r_t1 <= w_prod;
        end
        if (i_cmd.mul_en && (i_cmd.mul_sel == MS_T2)) begin
            r_t2 <= w_prod;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_err) begin
                r_out.result_num <= '0;
                r_out.result_den <= DEN_OUT_WIDTH'(1);
                r_out.equal      <= 1'b0;
                r_out.error      <= 1'b1;
            end else begin
                r_out.result_num <= w_num_ext[NUM_OUT_WIDTH-1:0];
                r_out.result_den <= w_src_den[DEN_OUT_WIDTH-1:0];
                r_out.equal      <= w_eq;
                r_out.error      <= 1'b0;
            end
        end
    end

    // Status to controller
    assign o_stat.op        = r_in.operation;
    assign o_stat.err_zero  = (r_in.a_den == '0)
                              || ((r_in.operation != OP_NORM) && (r_in.b_den == '0));
    assign o_stat.y_zero    = (r_y == '0);
    assign o_stat.div_done  = w_div_done;
    assign o_stat.out_valid = r_out_valid;

    assign o_rsp       = r_out;
    assign o_rsp_valid = r_out_valid;

endmodule

/* hdl/rac_ctrl.sv */
// Controller: sequences reduction of a, b and the combined result.
module rac_ctrl import rac_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  logic     i_rsp_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_req_ready
);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_A;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.err_zero) begin
                    o_cmd.set_err = 1'b1;
                    n_state       = ST_OUT;
                end else begin
                    o_cmd.load_a = 1'b1;
                    n_phase      = PH_A;
                    n_state      = ST_GCD_TEST;
                end
            end
            ST_GCD_TEST: begin
                o_cmd.div_start = 1'b1;
                if (i_stat.y_zero) begin
                    o_cmd.div_src = DS_MAG;
                    n_state       = ST_DIVM_WAIT;
                end else begin
                    o_cmd.div_src = DS_GCD;
                    n_state       = ST_GCD_WAIT;
                end
            end
            ST_GCD_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.gcd_update = 1'b1;
                    n_state          = ST_GCD_TEST;
                end
            end
            ST_DIVM_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.wr_mag    = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_src   = DS_DEN;
                    n_state         = ST_DIVD_WAIT;
                end
            end
            ST_DIVD_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.wr_den = 1'b1;
                    n_state      = ST_REDUCED;
                end
            end
            ST_REDUCED: begin
                case (r_phase)
                    PH_A: begin
                        o_cmd.save_a = 1'b1;
                        if (i_stat.op == OP_NORM) begin
                            n_state = ST_OUT;
                        end else begin
                            o_cmd.load_b = 1'b1;
                            n_phase      = PH_B;
                            n_state      = ST_GCD_TEST;
                        end
                    end
                    PH_B: begin
                        o_cmd.save_b = 1'b1;
                        n_state = (i_stat.op == OP_EQ) ? ST_OUT : ST_MUL1;
                    end
                    default: begin
                        n_state = ST_OUT;
                    end
                endcase
            end
            ST_MUL1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_T1;
                n_state       = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_T2;
                n_state       = ST_MUL3;
            end
            ST_MUL3: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_DEN;
                n_state       = ST_COMBINE;
            end
            ST_COMBINE: begin
                o_cmd.combine = 1'b1;
                n_phase       = PH_R;
                n_state       = ST_GCD_TEST;
            end
            ST_OUT: begin
                // Load the result once the output register is free
                if (!i_stat.out_valid || i_rsp_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/rac_checker.sv */
// Port-level checker for the rational core, with its bind.
module rac_checker import rac_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input t_req i_req,
    input logic o_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp o_rsp
);

    // Stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response changed while stalled");

    // Error responses are forced to 0/1
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.error |->
            (o_rsp.result_num == '0) && (o_rsp.result_den == 32'd1) && !o_rsp.equal)
        else $error("error response not 0/1");

    // A zero result is always 0/1
    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.result_num == '0) |-> (o_rsp.result_den == 32'd1))
        else $error("zero numerator without unit denominator");

    // No response right after reset
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid after reset");

endmodule

bind rational_add_sub_compare_core rac_checker u_rac_checker (.*);

/* dv/rational_checker.sv */
// Checker for the rational core: watches both channels, predicts and compares responses.
`timescale 1ns / 100ps

module rational_checker import rac_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  t_req        i_req,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  t_rsp        i_rsp,
    output int          o_fail_count,
    output int          o_pending
);

    // Reduced fraction in sign/magnitude form
    typedef struct {
        bit              neg;
        longint unsigned mag;
        longint unsigned den;
    } t_frac;

    t_rsp expected_rsps[$];

    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return (x == 0) ? 1 : x;
    endfunction

    function automatic t_frac reduce_frac(t_frac f);
        longint unsigned g;
        g = gcd_of(f.mag, f.den);
        f.mag = f.mag / g;
        f.den = f.den / g;
        if (f.mag == 0) begin
            f.neg = 0;
            f.den = 1;
        end
        return f;
    endfunction

    // Build a reduced fraction from raw operands; the sign goes to the numerator
    function automatic t_frac make_frac(logic [OPERAND_WIDTH-1:0] n,
                                        logic [OPERAND_WIDTH-1:0] d);
        t_frac f;
        longint signed sn, sd;
        sn = longint'($signed(n));
        sd = longint'($signed(d));
        f.neg = (sn < 0) != (sd < 0);
        f.mag = (sn < 0) ? -sn : sn;
        f.den = (sd < 0) ? -sd : sd;
        return reduce_frac(f);
    endfunction

    function automatic t_rsp rational_result(t_req r);
        t_rsp            o;
        t_frac           fa, fb, fr;
        bit              bneg;
        longint unsigned t1, t2;
        o = '0;
        if (r.a_den == 0 || (r.operation != OP_NORM && r.b_den == 0)) begin
            o.result_den = 1;
            o.error      = 1'b1;
            return o;
        end
        fa = make_frac(r.a_num, r.a_den);
        fb = make_frac(r.b_num, r.b_den);
        fr = fa;
        if (r.operation == OP_EQ) begin
            o.equal = (fa.neg == fb.neg) && (fa.mag == fb.mag) && (fa.den == fb.den);
        end else if (r.operation != OP_NORM) begin
            bneg = (r.operation == OP_SUB) ? !fb.neg : fb.neg;
            t1 = fa.mag * fb.den;
            t2 = fb.mag * fa.den;
            if (fa.neg == bneg) begin
                fr.mag = t1 + t2;
                fr.neg = fa.neg;
            end else if (t1 >= t2) begin
                fr.mag = t1 - t2;
                fr.neg = fa.neg;
            end else begin
                fr.mag = t2 - t1;
                fr.neg = bneg;
            end
            fr.den = fa.den * fb.den;
            fr = reduce_frac(fr);
        end
        o.result_num = fr.neg ? NUM_OUT_WIDTH'(-fr.mag) : NUM_OUT_WIDTH'(fr.mag);
        o.result_den = DEN_OUT_WIDTH'(fr.den);
        return o;
    endfunction

    // Predict on each accepted request, compare on each accepted response
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && i_req_valid && i_req_ready)
            expected_rsps.push_back(rational_result(i_req));
        if (i_rst_n && i_rsp_valid && i_rsp_ready) begin
            if (expected_rsps.size() == 0) begin
                if (o_fail_count < 10)
                    $display("Unexpected response: %p", i_rsp);
                o_fail_count <= o_fail_count + 1;
            end else begin
                exp_rsp = expected_rsps.pop_front();
                if (exp_rsp !== i_rsp) begin
                    if (o_fail_count < 10)
                        $display({"Response mismatch: exp num=%0d den=%0d eq=%b err=%b,",
                                  " got num=%0d den=%0d eq=%b err=%b"},
                                 exp_rsp.result_num, exp_rsp.result_den,
                                 exp_rsp.equal, exp_rsp.error,
                                 i_rsp.result_num, i_rsp.result_den,
                                 i_rsp.equal, i_rsp.error);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
        o_pending <= expected_rsps.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

/* dv/testbench.sv */
// Stimulus and verdict for the rational add/subtract/compare core.
`timescale 1ns / 100ps

module testbench;
    import rac_pkg::*;

    localparam int RANDOM_REQS = 1030;
    localparam int IDLE_LIMIT  = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_ready;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_ready;
    t_rsp o_rsp;
    int   fail_count;
    int   pending;
    int   idle_cycles;

    rational_add_sub_compare_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    rational_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req_ready  (o_req_ready),
        .i_req        (i_req),
        .i_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Operand value biased toward edge cases and small numbers sharing factors
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 4)) - 2);
            3, 4: return 16'(int'($urandom_range(0, 48)) - 24);
            5: return 16'(($urandom_range(1, 60)) * (($urandom_range(0, 1)) ? 64 : -36));
            default: return 16'($urandom);
        endcase
    endfunction

    // Send one request after a random gap, hold it until accepted
    task automatic send_req(t_op op, logic [15:0] an, logic [15:0] ad,
                            logic [15:0] bn, logic [15:0] bd);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= '{op, an, ad, bn, bd};
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
    endtask

    // Random response stalls
    initial begin
        int rsp_gap;
        i_rsp_ready = 1'b0;
        @(posedge i_rst_n);
        i_rsp_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            while (!o_rsp_valid) @(posedge i_clk);
            rsp_gap = $urandom_range(0, 9);
            if (rsp_gap > 0) begin
                i_rsp_ready <= 1'b0;
                repeat (rsp_gap) @(posedge i_clk);
                i_rsp_ready <= 1'b1;
            end
        end
    end

    // Watchdog on accepted traffic
    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_req       = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, each operation, zero denominators, sign handling
        send_req(OP_NORM, 16'd1, 16'h8000, 16'd0, 16'd0);
        send_req(OP_NORM, 16'h8000, 16'h8000, 16'd5, 16'd7);
        send_req(OP_NORM, 16'd0, 16'hfff9, 16'd0, 16'd0);
        send_req(OP_NORM, 16'd6, 16'd0, 16'd1, 16'd1);
        send_req(OP_NORM, 16'hfffa, 16'hfff7, 16'd0, 16'd0);
        send_req(OP_NORM, 16'h7fff, 16'h7ffe, 16'hffff, 16'hffff);
        send_req(OP_ADD, 16'h7fff, 16'h7ffe, 16'h7ffd, 16'h7fff);
        send_req(OP_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7ffe);
        send_req(OP_ADD, 16'd1, 16'd2, 16'd1, 16'd2);
        send_req(OP_ADD, 16'd1, 16'd3, 16'hffff, 16'd3);
        send_req(OP_ADD, 16'd1, 16'd1, 16'd1, 16'd0);
        send_req(OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_req(OP_SUB, 16'd3, 16'd4, 16'd3, 16'd4);
        send_req(OP_SUB, 16'd1, 16'd3, 16'd1, 16'd2);
        send_req(OP_SUB, 16'd1, 16'd0, 16'd1, 16'd0);
        send_req(OP_EQ, 16'd2, 16'd4, 16'hffff, 16'hfffe);
        send_req(OP_EQ, 16'd2, 16'hfffc, 16'd1, 16'd2);
        send_req(OP_EQ, 16'd0, 16'd5, 16'd0, 16'hfff1);
        send_req(OP_EQ, 16'd1, 16'd2, 16'd1, 16'd0);
        send_req(OP_EQ, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);

        // Random requests; mostly nonzero denominators, equal pairs now and then
        for (int i = 0; i < RANDOM_REQS; i++) begin
            logic [15:0] an, ad, bn, bd;
            int          k;
            an = pick_operand();
            ad = pick_operand();
            bn = pick_operand();
            bd = pick_operand();
            if (ad == 0 && $urandom_range(0, 3) != 0) ad = 16'd1;
            if (bd == 0 && $urandom_range(0, 3) != 0) bd = 16'hffff;
            if ($urandom_range(0, 5) == 0) begin
                k  = $urandom_range(1, 5);
                bn = 16'(int'($signed(an)) * k * (($urandom_range(0, 1)) ? 1 : -1));
                bd = 16'(int'($signed(ad)) * k * (($signed(bn) == $signed(an) * k) ? 1 : -1));
            end
            send_req(t_op'($urandom_range(0, 3)), an, ad, bn, bd);
        end
        i_req_valid <= 1'b0;

        // Wait for the last response, then a quiet tail
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* rational_add_sub_compare_core.f */
hdl/rac_pkg.sv
hdl/rac_div.sv
hdl/rac_datapath.sv
hdl/rac_ctrl.sv
hdl/rational_add_sub_compare_core.sv
hdl/rac_checker.sv
dv/rational_checker.sv
dv/testbench.sv
